// ===== design/hpd_pkg.sv =====
// shared constants and types of the host pair dedupe counter table
package hpd_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int LEN_W   = 16;
    localparam int CTR_W   = 32;
    localparam int SLOT_W  = 6;
    localparam int HOSTS_W = 7;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 144;
    localparam int FLAG_W  = 3;

    typedef struct packed {
        logic [LEN_W-1:0] pkt_length;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
    } item_t;

    typedef struct packed {
        logic [CTR_W-1:0] total_bytes;
        logic [HOSTS_W-1:0] total_hosts;
        logic [CTR_W-1:0] total_packets;
        logic [CTR_W-1:0] host_bytes;
        logic [CTR_W-1:0] host_packets;
        logic [SLOT_W-1:0] slot;
        logic             table_full;
        logic             new_host;
        logic             matched;
    } result_t;

endpackage

// ===== design/hpd_front.sv =====
// front end: input acceptance and two-entry item queue
module hpd_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hpd_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_pop,
    output hpd_pkg::item_t q_item
);

    hpd_pkg::item_t buf_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/hpd_back.sv =====
// back end: table scan sequencer, entry memory, counters and result register
module hpd_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_pop,
    input  hpd_pkg::item_t   q_item,
    output logic             out_valid,
    input  logic             out_ready,
    output hpd_pkg::result_t out_result
);

    typedef enum logic [1:0] {IDLE, SCAN, MISS} state_t;

    typedef struct packed {
        logic [hpd_pkg::IP_W-1:0]  ip;
        logic [hpd_pkg::MAC_W-1:0] mac;
        logic [hpd_pkg::CTR_W-1:0] packets;
        logic [hpd_pkg::CTR_W-1:0] bytes;
    } entry_t;

    function automatic logic [hpd_pkg::CTR_W-1:0] sat_add(
        input logic [hpd_pkg::CTR_W-1:0] a,
        input logic [hpd_pkg::CTR_W-1:0] b
    );
        logic [hpd_pkg::CTR_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[hpd_pkg::CTR_W] ? '1 : s[hpd_pkg::CTR_W-1:0];
        end
    endfunction

    entry_t                        table_mem [hpd_pkg::DEPTH];
    entry_t                        rd_data_reg;
    state_t                        state_reg;
    hpd_pkg::item_t                cur_reg;
    logic [hpd_pkg::ADDR_W-1:0]    scan_reg;
    logic [hpd_pkg::CNT_W-1:0]     hosts_reg;
    logic [hpd_pkg::CTR_W-1:0]     pkt_total_reg;
    logic [hpd_pkg::CTR_W-1:0]     byte_total_reg;
    logic                          out_valid_reg;
    hpd_pkg::result_t              out_reg;

    logic                          start;
    logic                          hit;
    logic                          last;
    logic                          done;
    logic [hpd_pkg::ADDR_W-1:0]    rd_addr;
    logic                          wr_en;
    logic [hpd_pkg::ADDR_W-1:0]    wr_addr;
    entry_t                        wr_data;
    logic [hpd_pkg::CNT_W-1:0]     hosts_next;
    logic [hpd_pkg::CTR_W-1:0]     len_ext;
    logic [hpd_pkg::CTR_W-1:0]     pkt_total_next;
    logic [hpd_pkg::CTR_W-1:0]     byte_total_next;
    hpd_pkg::result_t              res_next;

    assign start   = (state_reg == IDLE) && q_valid && (!out_valid_reg || out_ready);
    assign q_pop   = start;
    assign rd_addr = (state_reg == SCAN) ? scan_reg + 1'b1 : '0;
    assign hit     = (rd_data_reg.ip == cur_reg.sender_ip)
                  && (rd_data_reg.mac == cur_reg.sender_mac);
    assign last    = ((hpd_pkg::CNT_W'(scan_reg) + 1'b1) == hosts_reg);
    assign len_ext = hpd_pkg::CTR_W'(cur_reg.pkt_length);
    assign pkt_total_next  = sat_add(pkt_total_reg, hpd_pkg::CTR_W'(1));
    assign byte_total_next = sat_add(byte_total_reg, len_ext);

    always_comb
    begin
        done       = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = scan_reg;
        wr_data    = rd_data_reg;
        hosts_next = hosts_reg;
        res_next   = '0;
        case (state_reg)
            SCAN:
            begin
                if (hit)
                begin
                    done                  = 1'b1;
                    wr_en                 = 1'b1;
                    wr_data.packets       = sat_add(rd_data_reg.packets, hpd_pkg::CTR_W'(1));
                    wr_data.bytes         = sat_add(rd_data_reg.bytes, len_ext);
                    res_next.matched      = 1'b1;
                    res_next.slot         = hpd_pkg::SLOT_W'(scan_reg);
                    res_next.host_packets = wr_data.packets;
                    res_next.host_bytes   = wr_data.bytes;
                end
            end
            MISS:
            begin
                done = 1'b1;
                if (hosts_reg < hpd_pkg::CNT_W'(hpd_pkg::DEPTH))
                begin
                    wr_en                 = 1'b1;
                    wr_addr               = hpd_pkg::ADDR_W'(hosts_reg);
                    wr_data.ip            = cur_reg.sender_ip;
                    wr_data.mac           = cur_reg.sender_mac;
                    wr_data.packets       = hpd_pkg::CTR_W'(1);
                    wr_data.bytes         = len_ext;
                    hosts_next            = hosts_reg + 1'b1;
                    res_next.new_host     = 1'b1;
                    res_next.slot         = hpd_pkg::SLOT_W'(hosts_reg);
                    res_next.host_packets = hpd_pkg::CTR_W'(1);
                    res_next.host_bytes   = len_ext;
                end
                else
                begin
                    res_next.table_full = 1'b1;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
        res_next.total_packets = pkt_total_next;
        res_next.total_bytes   = byte_total_next;
        res_next.total_hosts   = hpd_pkg::HOSTS_W'(hosts_next);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            cur_reg        <= '0;
            scan_reg       <= '0;
            hosts_reg      <= '0;
            pkt_total_reg  <= '0;
            byte_total_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        cur_reg   <= q_item;
                        scan_reg  <= '0;
                        state_reg <= (hosts_reg == '0) ? MISS : SCAN;
                    end
                end
                SCAN:
                begin
                    if (hit)
                    begin
                        state_reg <= IDLE;
                    end
                    else if (last)
                    begin
                        state_reg <= MISS;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                MISS:
                begin
                    state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
            if (done)
            begin
                hosts_reg      <= hosts_next;
                pkt_total_reg  <= pkt_total_next;
                byte_total_reg <= byte_total_next;
                out_reg        <= res_next;
                out_valid_reg  <= 1'b1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

// ===== design/host_pair_dedupe_counter_table_core.sv =====
// top level of the host pair dedupe counter table
//
// usage
// - s_axis carries one captured reply per transfer: sender ip, sender mac and
//   packet length in s_axis_tdata
// - m_axis returns one result per reply: match, new host and table full flags
//   in m_axis_tuser, slot, entry counters and global totals in m_axis_tdata
// - a two-entry queue takes replies while the table sequencer is busy
// - the sequencer reads one table entry per cycle from a memory with one read
//   and one write port; a reply that misses scans every valid entry before it
//   is added as a new host or flagged table full, and one that matches entry
//   slot stops the scan there; the sequencer takes the next reply only from
//   idle, so the scan length sets the rate
// - a reply passes the queue, the current item register and the result register
// - reset empties the queue, the host count and both global totals; entries
//   are valid below the host count, so the table needs no clearing pass
// - while m_axis_tready is low the result holds in its register, the queue
//   keeps filling and the sequencer waits before starting the next reply
module host_pair_dedupe_counter_table_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hpd_pkg::IN_W-1:0]      s_axis_tdata,   // sender_ip, sender_mac, pkt_length
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hpd_pkg::OUT_W-1:0]     m_axis_tdata,   // slot, host_packets, host_bytes,
                                                          // total_packets, total_hosts,
                                                          // total_bytes, zero fill
    output logic [hpd_pkg::FLAG_W-1:0]    m_axis_tuser    // matched, new_host, table_full
);

    hpd_pkg::item_t   in_item;
    hpd_pkg::item_t   q_item;
    hpd_pkg::result_t result;
    logic             q_valid;
    logic             q_pop;

    assign in_item = s_axis_tdata;

    hpd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    hpd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tuser = {result.table_full, result.new_host, result.matched};
    assign m_axis_tdata = {3'b000, result.total_bytes, result.total_hosts,
                           result.total_packets, result.host_bytes,
                           result.host_packets, result.slot};

endmodule
